### hw/rtl/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types, field widths, calendar limits and the leap-year test for the
// calendar clock tick core.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;

    // Last value of each field before it wraps
    localparam logic [SEC_W-1:0]   SEC_LAST   = 6'd59;
    localparam logic [MIN_W-1:0]   MIN_LAST   = 6'd59;
    localparam logic [HOUR_W-1:0]  HOUR_LAST  = 5'd23;
    localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_LAST  = 14'd9999;

    localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [YEAR_W-1:0]  YEAR_RESET  = 14'd1970;

    // Month lengths
    localparam logic [DAY_W-1:0] DAYS_LONG     = 5'd31;
    localparam logic [DAY_W-1:0] DAYS_SHORT    = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;
    localparam logic [DAY_W-1:0] DAYS_FEB      = 5'd28;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SET  = 1'b1
    } t_cct_cmd;

    typedef struct packed {
        t_cct_cmd             cmd;
        logic [HOUR_W-1:0]    set_hour;
        logic [MIN_W-1:0]     set_minute;
        logic [SEC_W-1:0]     set_second;
        logic [DAY_W-1:0]     set_day;
        logic [MONTH_W-1:0]   set_month;
        logic [YEAR_W-1:0]    set_year;
    } t_cct_in;

    typedef struct packed {
        logic [HOUR_W-1:0]    hour;
        logic [MIN_W-1:0]     minute;
        logic [SEC_W-1:0]     second;
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_W-1:0]    year;
    } t_cct_out;

    localparam t_cct_out TIME_RESET = '{
        hour:   '0,
        minute: '0,
        second: '0,
        day:    DAY_FIRST,
        month:  MONTH_FIRST,
        year:   YEAR_RESET
    };

    // Gregorian leap test. The year modulo 25 is found by folding with
    // 128 = 3 (mod 25) twice, then at most three conditional subtracts.
    // Divisible by 100 means by 4 and by 25; by 400 means by 16 and by 25.
    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        logic [8:0] fold1;
        logic [7:0] fold2;
        logic [7:0] rem25;
        fold1 = {2'b00, year[6:0]} + {2'b00, year[13:7]} + {1'b0, year[13:7], 1'b0};
        fold2 = {1'b0, fold1[6:0]} + {6'b0, fold1[8:7]} + {5'b0, fold1[8:7], 1'b0};
        rem25 = fold2;
        if (rem25 >= 8'd100) begin
            rem25 = rem25 - 8'd100;
        end
        if (rem25 >= 8'd50) begin
            rem25 = rem25 - 8'd50;
        end
        if (rem25 >= 8'd25) begin
            rem25 = rem25 - 8'd25;
        end
        return (year[1:0] == 2'b00) && ((rem25 != 8'd0) || (year[3:0] == 4'b0000));
    endfunction

endpackage

### hw/rtl/cct_next.sv
// ----------------------------------------------------------------------------
// cct_next
// Next-time logic: loads the set fields, or advances the held time by one
// second with the carry rippling through minute, hour, day, month and year.
// ----------------------------------------------------------------------------
module cct_next (
    input  cct_pkg::t_cct_in  i_word,
    input  cct_pkg::t_cct_out i_time,
    output cct_pkg::t_cct_out o_time
);
    import cct_pkg::*;

    logic             leap;
    logic [DAY_W-1:0] month_len;
    t_cct_out         next_time;

    // Length of the current month; undefined month codes take February's
    always_comb begin
        leap = is_leap(i_time.year);
        case (i_time.month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
                month_len = DAYS_LONG;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                month_len = DAYS_SHORT;
            end
            default: begin
                month_len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
            end
        endcase
    end

    // Load or advance; each field wraps only when everything below it wrapped
    always_comb begin
        next_time = i_time;
        if (i_word.cmd == CMD_SET) begin
            next_time.hour   = i_word.set_hour;
            next_time.minute = i_word.set_minute;
            next_time.second = i_word.set_second;
            next_time.day    = i_word.set_day;
            next_time.month  = i_word.set_month;
            next_time.year   = i_word.set_year;
        end else if (i_time.second < SEC_LAST) begin
            next_time.second = i_time.second + 1'b1;
        end else begin
            next_time.second = '0;
            if (i_time.minute < MIN_LAST) begin
                next_time.minute = i_time.minute + 1'b1;
            end else begin
                next_time.minute = '0;
                if (i_time.hour < HOUR_LAST) begin
                    next_time.hour = i_time.hour + 1'b1;
                end else begin
                    next_time.hour = '0;
                    if (i_time.day < month_len) begin
                        next_time.day = i_time.day + 1'b1;
                    end else begin
                        next_time.day = DAY_FIRST;
                        if (i_time.month < MONTH_LAST) begin
                            next_time.month = i_time.month + 1'b1;
                        end else begin
                            next_time.month = MONTH_FIRST;
                            next_time.year  = (i_time.year >= YEAR_LAST) ?
                                              '0 : i_time.year + 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign o_time = next_time;

endmodule

### hw/rtl/calendar_clock_tick_core.sv
// ----------------------------------------------------------------------------
// calendar_clock_tick_core
// Real-time clock and calendar. Each input word either advances the time by
// one second (tick) or loads hour, minute, second, day, month and year as
// given; every word returns one output word with the time and date after it.
// Months follow the Gregorian leap rule and the year wraps from 9999 to 0.
// After reset the time is 00:00:00 on January 1, 1970. The core takes one
// word per cycle while the output side keeps taking results: a word waits in
// the input register, the combinational next-time logic updates the time
// register, and that register is the output word. The time register holds
// while a result waits to be taken, and the input register keeps taking
// words as long as the output side moves.
// ----------------------------------------------------------------------------
module calendar_clock_tick_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cct_pkg::t_cct_in  i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cct_pkg::t_cct_out o_out_word
);
    import cct_pkg::*;

    logic     r_in_valid;
    t_cct_in  r_in_word;
    t_cct_out r_time;
    logic     r_out_valid;
    t_cct_out n_time;
    logic     advance;

    // Move the held word into the time register when the output slot frees
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    cct_next u_next (
        .i_word (r_in_word),
        .i_time (r_time),
        .o_time (n_time)
    );

    // Control and time state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_time      <= TIME_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_time      <= n_time;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_time;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the calendar clock tick core. Drives load and tick
// words through the valid/ready input, mirrors the clock and calendar in a
// scoreboard, and compares every output word field by field. Covers the
// carry chain from second to year, month lengths, the leap-year rule,
// out-of-range loads and the year wrap. Random idling on both sides and a
// long output hold-off exercise back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import cct_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 64;
    localparam int PHASE_WORDS = 220;

    // Mirror of the calendar and the queue of words still owed by the core
    class calendar_scoreboard;
        t_cct_out clock_now;
        t_cct_out owed_q[$];
        int mismatches;
        int checked;
        int loads;
        int ticks;
        int day_rolls;
        int year_rolls;

        function new();
            clock_now = TIME_RESET;
            mismatches = 0;
            checked = 0;
            loads = 0;
            ticks = 0;
            day_rolls = 0;
            year_rolls = 0;
        endfunction

        // Advance one second and ripple the carries up to the year
        function void tick_second();
            int yr;
            int month_len;
            bit leap;
            yr = clock_now.year;
            leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
            case (clock_now.month)
                1, 3, 5, 7, 8, 10, 12: month_len = DAYS_LONG;
                4, 6, 9, 11:           month_len = DAYS_SHORT;
                default:               month_len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
            endcase
            if (int'(clock_now.second) + 1 <= int'(SEC_LAST)) begin
                clock_now.second = clock_now.second + 1'b1;
                return;
            end
            clock_now.second = '0;
            if (int'(clock_now.minute) + 1 <= int'(MIN_LAST)) begin
                clock_now.minute = clock_now.minute + 1'b1;
                return;
            end
            clock_now.minute = '0;
            if (int'(clock_now.hour) + 1 <= int'(HOUR_LAST)) begin
                clock_now.hour = clock_now.hour + 1'b1;
                return;
            end
            clock_now.hour = '0;
            if (int'(clock_now.day) + 1 <= month_len) begin
                clock_now.day = clock_now.day + 1'b1;
                return;
            end
            clock_now.day = DAY_FIRST;
            day_rolls++;
            if (int'(clock_now.month) + 1 <= int'(MONTH_LAST)) begin
                clock_now.month = clock_now.month + 1'b1;
                return;
            end
            clock_now.month = MONTH_FIRST;
            year_rolls++;
            if (clock_now.year >= YEAR_LAST) begin
                clock_now.year = '0;
            end else begin
                clock_now.year = clock_now.year + 1'b1;
            end
        endfunction

        // Apply an accepted input word and queue the word it must produce
        function void note_word(t_cct_in w);
            if (w.cmd == CMD_SET) begin
                clock_now.hour   = w.set_hour;
                clock_now.minute = w.set_minute;
                clock_now.second = w.set_second;
                clock_now.day    = w.set_day;
                clock_now.month  = w.set_month;
                clock_now.year   = w.set_year;
                loads++;
            end else begin
                tick_second();
                ticks++;
            end
            owed_q.push_back(clock_now);
        endfunction

        function void field_check(string name, int want, int got);
            if (want != got) begin
                $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // Compare an accepted output word with the oldest owed word
        function void check_word(t_cct_out got);
            t_cct_out want;
            if (owed_q.size() == 0) begin
                $display("%0t unexpected output word: expected none, got %p", $time, got);
                mismatches++;
                return;
            end
            want = owed_q.pop_front();
            checked++;
            field_check("hour",   want.hour,   got.hour);
            field_check("minute", want.minute, got.minute);
            field_check("second", want.second, got.second);
            field_check("day",    want.day,    got.day);
            field_check("month",  want.month,  got.month);
            field_check("year",   want.year,   got.year);
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    t_cct_in  in_word = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_cct_out out_word;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_count = 0;

    calendar_scoreboard sb = new();

    calendar_clock_tick_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always #10 clk = ~clk;

    // Drive ready: serve a long hold-off when asked, otherwise stall at random
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left <= HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check every output word taken
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_word(out_word);
        end
    end

    // Stop a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    function automatic t_cct_in tick_word();
        logic [63:0] raw;
        t_cct_in w;
        raw = {$urandom, $urandom};
        w = raw[$bits(t_cct_in)-1:0];
        w.cmd = CMD_TICK;
        return w;
    endfunction

    function automatic t_cct_in make_load(
        input logic [HOUR_W-1:0]  h,
        input logic [MIN_W-1:0]   m,
        input logic [SEC_W-1:0]   s,
        input logic [DAY_W-1:0]   d,
        input logic [MONTH_W-1:0] mo,
        input logic [YEAR_W-1:0]  y
    );
        t_cct_in w;
        w.cmd = CMD_SET;
        w.set_hour = h;
        w.set_minute = m;
        w.set_second = s;
        w.set_day = d;
        w.set_month = mo;
        w.set_year = y;
        return w;
    endfunction

    // Load word biased toward the edges of the carry chain
    function automatic t_cct_in random_load();
        logic [63:0] raw;
        t_cct_in w;
        raw = {$urandom, $urandom};
        w = raw[$bits(t_cct_in)-1:0];
        w.cmd = CMD_SET;
        // keep some loads as raw bits, out-of-range fields included
        if ($urandom_range(9) == 0) begin
            return w;
        end
        w.set_second = SEC_W'(($urandom_range(3) == 0) ? $urandom_range(59) :
                              59 - $urandom_range(2));
        w.set_minute = MIN_W'(($urandom_range(3) == 0) ? $urandom_range(59) :
                              59 - $urandom_range(1));
        w.set_hour = HOUR_W'(($urandom_range(3) == 0) ? $urandom_range(23) : 23);
        w.set_month = MONTH_W'($urandom_range(12, 1));
        w.set_day = DAY_W'(($urandom_range(3) == 0) ? $urandom_range(31, 1) :
                           $urandom_range(31, 27));
        case ($urandom_range(3))
            0: w.set_year = YEAR_W'($urandom_range(9999));
            1: w.set_year = YEAR_W'($urandom_range(99) * 100);
            2: w.set_year = YEAR_W'($urandom_range(2499) * 4);
            default: w.set_year = YEAR_W'(9999 - $urandom_range(1));
        endcase
        return w;
    endfunction

    // Offer one word after a random idle gap and hold it until taken
    task automatic send_word(input t_cct_in w);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        sb.note_word(w);
    endtask

    // Drop valid and wait until every owed word has come back
    task automatic drain();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (sb.owed_q.size() != 0);
    endtask

    task automatic run_phase(input int idle, input int stall, input bit with_hold,
                             input bit with_pause);
        idle_pct = idle;
        stall_pct <= stall;
        if (with_hold) begin
            hold_asked <= hold_asked + 1;
        end
        for (int i = 0; i < PHASE_WORDS; i++) begin
            if (with_pause && i == PHASE_WORDS / 2) begin
                drain();
            end
            send_word(($urandom_range(99) < 12) ? random_load() : tick_word());
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset value, each carry, month lengths, leap rule, wrap
        send_word(tick_word());
        send_word(make_load(10, 59, 59, 15, 6, 2023));
        send_word(tick_word());
        send_word(make_load(23, 59, 59, 31, 12, 9999));
        send_word(tick_word());
        send_word(make_load(23, 59, 59, 28, 2, 2024));
        send_word(tick_word());
        send_word(make_load(23, 59, 59, 29, 2, 2024));
        send_word(tick_word());
        send_word(make_load(23, 59, 59, 28, 2, 1900));
        send_word(tick_word());
        send_word(make_load(23, 59, 59, 28, 2, 2000));
        send_word(tick_word());
        send_word(make_load(23, 59, 59, 30, 4, 2023));
        send_word(tick_word());
        send_word(make_load(23, 59, 59, 0, 6, 2023));
        send_word(tick_word());
        send_word(make_load(23, 59, 59, 28, 0, 2023));
        send_word(tick_word());
        send_word(make_load(23, 59, 59, 29, 13, 2024));
        send_word(tick_word());
        send_word(make_load(31, 63, 63, 31, 15, 16383));
        send_word(tick_word());
        send_word(make_load(0, 0, 0, 0, 0, 0));
        send_word(tick_word());
        drain();

        // Random: free flow with a long hold-off, then each idling mix
        run_phase(0, 0, 1'b1, 1'b1);
        run_phase(46, 0, 1'b0, 1'b0);
        run_phase(0, 46, 1'b0, 1'b0);
        run_phase(6, 6, 1'b0, 1'b0);

        repeat (8) @(posedge clk);
        $display("covered %0d words: %0d loads, %0d ticks, %0d output words compared",
                 sb.loads + sb.ticks, sb.loads, sb.ticks, sb.checked);
        $display("carries into a new month: %0d, into a new year: %0d",
                 sb.day_rolls, sb.year_rolls);
        if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
